// ===== rtl/msqrt_pkg.sv =====
// shared constants, status codes and the modular add helper
// for the modular square root block; no dependencies
package msqrt_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int M_W   = $clog2(WIDTH) + 1;

    localparam logic [WIDTH-1:0] ONE  = WIDTH'(1);
    localparam logic [WIDTH-1:0] ZERO = '0;

    typedef logic [WIDTH-1:0] word_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NONRES = 2'd1;
    localparam logic [1:0] ST_BADMOD = 2'd2;

    // operands below p, one add and one compare-subtract
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t p);
        logic [WIDTH:0] sum;
        logic [WIDTH:0] red;
        sum = {1'b0, x} + {1'b0, y};
        red = sum - {1'b0, p};
        add_mod = (sum >= {1'b0, p}) ? red[WIDTH-1:0] : sum[WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/msqrt_in_if.sv =====
// request channel of the modular square root block
// depends on msqrt_pkg
interface msqrt_in_if;
    import msqrt_pkg::*;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [31:0] modulus;
    modport source (output valid, output value, output modulus, input ready);
    modport sink (input valid, input value, input modulus, output ready);
endinterface

// ===== rtl/msqrt_out_if.sv =====
// result channel of the modular square root block
// depends on msqrt_pkg
interface msqrt_out_if;
    import msqrt_pkg::*;
    logic        valid;
    logic        ready;
    logic [31:0] root;
    logic [1:0]  status;
    modport source (output valid, output root, output status, input ready);
    modport sink (input valid, input root, input status, output ready);
endinterface

// ===== rtl/msqrt_mulmod.sv =====
// bit-serial modular multiplier, one multiplier bit per cycle
// depends on msqrt_pkg
module msqrt_mulmod (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  msqrt_pkg::word_t    x,
    input  msqrt_pkg::word_t    y,
    input  msqrt_pkg::word_t    p,
    output logic                done,
    output msqrt_pkg::word_t    prod
);
    import msqrt_pkg::*;

    word_t            acc_reg, acc_next;
    word_t            x_reg, x_next;
    word_t            y_reg, y_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = ZERO;
            x_next    = x;
            y_next    = y;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_reg[0])
                acc_next = add_mod(acc_reg, x_reg, p);
            x_next   = add_mod(x_reg, x_reg, p);
            y_next   = y_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("multiplier restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without a run");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("busy after done");
`endif

endmodule

// ===== rtl/modular_square_root.sv =====
// modular square root by tonelli-shanks, sequencer and output register
// depends on msqrt_pkg, msqrt_in_if, msqrt_out_if, msqrt_mulmod
//
//  channel | dir | fields                      | notes
//  din     | in  | value[31:0], modulus[31:0]  | ready only while idle
//  dout    | out | root[31:0], status[1:0]     | held in an output register
//
// one request at a time; every modular product runs through the
// bit-serial multiplier and an exponentiation takes up to 2*WIDTH
// products, followed by the tonelli-shanks rounds; a bad modulus skips
// the reduction and goes from idle straight to the finish state
// reset clears the sequencer and the output valid flag
// a result waiting on dout holds the sequencer in its finish state
module modular_square_root (
    input  logic         clk,
    input  logic         rst_n,
    msqrt_in_if.sink     din,
    msqrt_out_if.source  dout
);
    import msqrt_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RED   = 5'd1;
    localparam logic [4:0] S_PW    = 5'd2;
    localparam logic [4:0] S_PWM1  = 5'd3;
    localparam logic [4:0] S_PWM2  = 5'd4;
    localparam logic [4:0] S_CHKA  = 5'd5;
    localparam logic [4:0] S_STRIP = 5'd6;
    localparam logic [4:0] S_CHKZ  = 5'd7;
    localparam logic [4:0] S_GOTC  = 5'd8;
    localparam logic [4:0] S_GOTT  = 5'd9;
    localparam logic [4:0] S_GOTR  = 5'd10;
    localparam logic [4:0] S_LOOP  = 5'd11;
    localparam logic [4:0] S_ORD   = 5'd12;
    localparam logic [4:0] S_ORDW  = 5'd13;
    localparam logic [4:0] S_SQB   = 5'd14;
    localparam logic [4:0] S_SQBW  = 5'd15;
    localparam logic [4:0] S_CW    = 5'd16;
    localparam logic [4:0] S_TW    = 5'd17;
    localparam logic [4:0] S_RW    = 5'd18;
    localparam logic [4:0] S_FIN   = 5'd19;

    logic [4:0]       state_reg, state_next;
    word_t            p_reg, p_next;
    word_t            a_reg, a_next;
    word_t            rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    // exponentiation sub-sequence
    word_t            pres_reg, pres_next;
    word_t            pbase_reg, pbase_next;
    word_t            pexp_reg, pexp_next;
    logic [4:0]       pret_reg, pret_next;
    // tonelli-shanks variables
    word_t            q_reg, q_next;
    word_t            z_reg, z_next;
    word_t            c_reg, c_next;
    word_t            t_reg, t_next;
    word_t            r_reg, r_next;
    word_t            t2_reg, t2_next;
    word_t            b_reg, b_next;
    logic [M_W-1:0]   m_reg, m_next;
    logic [M_W-1:0]   i_reg, i_next;
    logic [M_W-1:0]   k_reg, k_next;
    // finished result and output register
    word_t            fin_root_reg, fin_root_next;
    logic [1:0]       fin_st_reg, fin_st_next;
    logic             ov_reg, ov_next;
    logic [31:0]      oroot_reg, oroot_next;
    logic [1:0]       ost_reg, ost_next;

    logic           mul_start;
    word_t          mul_x, mul_y;
    logic           mul_done;
    word_t          mul_prod;
    word_t          pm1;
    word_t          half;
    logic [WIDTH:0] rem2;
    logic [WIDTH:0] rem_sub;
    logic [WIDTH:0] z_inc;
    logic [M_W:0]   kim;

    assign pm1     = p_reg - ONE;
    assign half    = pm1 >> 1;
    assign rem2    = {rem_reg, a_reg[WIDTH-1]};
    assign rem_sub = rem2 - {1'b0, p_reg};
    assign z_inc   = {1'b0, z_reg} + {1'b0, ONE};
    assign kim     = {1'b0, k_reg} + {1'b0, i_reg} + (M_W + 1)'(1);

    msqrt_mulmod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .p     (p_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_comb
    begin
        state_next    = state_reg;
        p_next        = p_reg;
        a_next        = a_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        pres_next     = pres_reg;
        pbase_next    = pbase_reg;
        pexp_next     = pexp_reg;
        pret_next     = pret_reg;
        q_next        = q_reg;
        z_next        = z_reg;
        c_next        = c_reg;
        t_next        = t_reg;
        r_next        = r_reg;
        t2_next       = t2_reg;
        b_next        = b_reg;
        m_next        = m_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        fin_root_next = fin_root_reg;
        fin_st_next   = fin_st_reg;
        ov_next       = ov_reg;
        oroot_next    = oroot_reg;
        ost_next      = ost_reg;
        mul_start     = 1'b0;
        mul_x         = pres_reg;
        mul_y         = pbase_reg;

        if (ov_reg && dout.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (din.valid)
                begin
                    p_next   = din.modulus[WIDTH-1:0];
                    a_next   = din.value[WIDTH-1:0];
                    rem_next = ZERO;
                    cnt_next = '0;
                    // even modulus or modulus one
                    if (!din.modulus[0] || din.modulus[WIDTH-1:0] == ONE)
                    begin
                        fin_root_next = ZERO;
                        fin_st_next   = ST_BADMOD;
                        state_next    = S_FIN;
                    end
                    else
                        state_next = S_RED;
                end
            end
            S_RED:
            begin
                // restoring reduction, one value bit per cycle
                rem_next = (rem2 >= {1'b0, p_reg}) ? rem_sub[WIDTH-1:0]
                                                   : rem2[WIDTH-1:0];
                a_next   = a_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1))
                    state_next = S_CHKA;
            end
            S_PW:
            begin
                if (pexp_reg == ZERO)
                    state_next = pret_reg;
                else if (pexp_reg[0])
                begin
                    mul_start  = 1'b1;
                    state_next = S_PWM1;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_x      = pbase_reg;
                    state_next = S_PWM2;
                end
            end
            S_PWM1:
            begin
                mul_x = pbase_reg;
                if (mul_done)
                begin
                    pres_next  = mul_prod;
                    mul_start  = 1'b1;
                    state_next = S_PWM2;
                end
            end
            S_PWM2:
            begin
                if (mul_done)
                begin
                    pbase_next = mul_prod;
                    pexp_next  = pexp_reg >> 1;
                    state_next = S_PW;
                end
            end
            S_CHKA:
            begin
                // first pass through: reduced value is in rem, start euler test
                if (pret_reg != S_CHKA)
                begin
                    a_next     = rem_reg;
                    pres_next  = ONE;
                    pbase_next = rem_reg;
                    pexp_next  = half;
                    pret_next  = S_CHKA;
                    state_next = S_PW;
                end
                else if (pres_reg != ONE)
                begin
                    fin_root_next = ZERO;
                    fin_st_next   = ST_NONRES;
                    state_next    = S_FIN;
                end
                else
                begin
                    q_next     = pm1;
                    m_next     = '0;
                    state_next = S_STRIP;
                end
            end
            S_STRIP:
            begin
                if (!q_reg[0])
                begin
                    q_next = q_reg >> 1;
                    m_next = m_reg + 1'b1;
                end
                else
                begin
                    z_next     = ONE;
                    pres_next  = ONE;
                    pbase_next = ONE;
                    pexp_next  = half;
                    pret_next  = S_CHKZ;
                    state_next = S_PW;
                end
            end
            S_CHKZ:
            begin
                if (pres_reg != ONE)
                begin
                    // non-residue found
                    pres_next  = ONE;
                    pbase_next = z_reg;
                    pexp_next  = q_reg;
                    pret_next  = S_GOTC;
                    state_next = S_PW;
                end
                else if (z_inc == {1'b0, p_reg})
                begin
                    fin_root_next = ZERO;
                    fin_st_next   = ST_NONRES;
                    state_next    = S_FIN;
                end
                else
                begin
                    z_next     = z_inc[WIDTH-1:0];
                    pres_next  = ONE;
                    pbase_next = z_inc[WIDTH-1:0];
                    pexp_next  = half;
                    state_next = S_PW;
                end
            end
            S_GOTC:
            begin
                c_next     = pres_reg;
                pres_next  = ONE;
                pbase_next = a_reg;
                pexp_next  = q_reg;
                pret_next  = S_GOTT;
                state_next = S_PW;
            end
            S_GOTT:
            begin
                t_next     = pres_reg;
                pres_next  = ONE;
                pbase_next = a_reg;
                pexp_next  = (q_reg >> 1) + ONE;
                pret_next  = S_GOTR;
                state_next = S_PW;
            end
            S_GOTR:
            begin
                r_next     = pres_reg;
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (t_reg == ONE)
                begin
                    fin_root_next = r_reg;
                    fin_st_next   = ST_OK;
                    state_next    = S_FIN;
                end
                else if (t_reg == ZERO)
                begin
                    fin_root_next = ZERO;
                    fin_st_next   = ST_NONRES;
                    state_next    = S_FIN;
                end
                else
                begin
                    t2_next    = t_reg;
                    i_next     = M_W'(1);
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                // least order search bounded by m
                mul_x = t2_reg;
                mul_y = t2_reg;
                if (i_reg >= m_reg)
                begin
                    fin_root_next = ZERO;
                    fin_st_next   = ST_NONRES;
                    state_next    = S_FIN;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = S_ORDW;
                end
            end
            S_ORDW:
            begin
                if (mul_done)
                begin
                    t2_next = mul_prod;
                    if (mul_prod == ONE)
                    begin
                        b_next     = c_reg;
                        k_next     = '0;
                        state_next = S_SQB;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            S_SQB:
            begin
                mul_x     = b_reg;
                mul_y     = b_reg;
                mul_start = 1'b1;
                if (kim < {1'b0, m_reg})
                    state_next = S_SQBW;
                else
                begin
                    m_next     = i_reg;
                    state_next = S_CW;
                end
            end
            S_SQBW:
            begin
                if (mul_done)
                begin
                    b_next     = mul_prod;
                    k_next     = k_reg + 1'b1;
                    state_next = S_SQB;
                end
            end
            S_CW:
            begin
                mul_x = t_reg;
                mul_y = mul_prod;
                if (mul_done)
                begin
                    c_next     = mul_prod;
                    mul_start  = 1'b1;
                    state_next = S_TW;
                end
            end
            S_TW:
            begin
                mul_x = r_reg;
                mul_y = b_reg;
                if (mul_done)
                begin
                    t_next     = mul_prod;
                    mul_start  = 1'b1;
                    state_next = S_RW;
                end
            end
            S_RW:
            begin
                if (mul_done)
                begin
                    r_next     = mul_prod;
                    state_next = S_LOOP;
                end
            end
            S_FIN:
            begin
                // wait for a free output register
                if (!ov_reg || dout.ready)
                begin
                    ov_next    = 1'b1;
                    oroot_next = 32'(fin_root_reg);
                    ost_next   = fin_st_reg;
                    pret_next  = S_IDLE;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pret_reg  <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pret_reg  <= pret_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        a_reg        <= a_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        pres_reg     <= pres_next;
        pbase_reg    <= pbase_next;
        pexp_reg     <= pexp_next;
        q_reg        <= q_next;
        z_reg        <= z_next;
        c_reg        <= c_next;
        t_reg        <= t_next;
        r_reg        <= r_next;
        t2_reg       <= t2_next;
        b_reg        <= b_next;
        m_reg        <= m_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        fin_root_reg <= fin_root_next;
        fin_st_reg   <= fin_st_next;
        oroot_reg    <= oroot_next;
        ost_reg      <= ost_next;
    end

    assign din.ready   = (state_reg == S_IDLE);
    assign dout.valid  = ov_reg;
    assign dout.root   = oroot_reg;
    assign dout.status = ost_reg;

`ifndef SYNTHESIS
    a_red_odd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RED |-> p_reg[0]) else $error("reduction with even modulus");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> dout.status != 2'd3) else $error("undefined status code");
    a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.status != ST_OK |-> dout.root == 32'd0)
        else $error("nonzero root on failure");
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg != S_IDLE && state_reg != S_FIN)
        else $error("product arrived with no one waiting");
`endif

endmodule

// ===== bench/modular_square_root_test.sv =====
// self-checking bench for modular_square_root: random and directed requests
// depends on msqrt_pkg, msqrt_in_if, msqrt_out_if and the block itself

class sqrt_scoreboard;
    typedef struct {
        msqrt_pkg::word_t value;
        msqrt_pkg::word_t modulus;
        msqrt_pkg::word_t root;
        logic [1:0]       status;
    } root_expect_t;

    root_expect_t expected_roots[$];
    int           errors;

    function new();
        errors = 0;
    endfunction

    static function longint unsigned mult_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned p);
        return (a * b) % p;
    endfunction

    static function longint unsigned power_mod(longint unsigned base, longint unsigned e,
                                               longint unsigned p);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1 % p;
        sq = base % p;
        while (e != 0)
        begin
            if (e[0])
                acc = mult_mod(acc, sq, p);
            sq = mult_mod(sq, sq, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    static function bit passes_euler(longint unsigned a, longint unsigned p);
        return power_mod(a, (p - 1) >> 1, p) == 1;
    endfunction

    // tonelli-shanks with the same give-up rules as the block
    static function void solve_root(input msqrt_pkg::word_t value, input msqrt_pkg::word_t modulus,
                                    output msqrt_pkg::word_t root, output logic [1:0] status);
        longint unsigned p, a, q, z, c, t, r, m, i, t2, b, k;
        p = modulus;
        a = value;
        root = '0;
        if (p < 3 || p[0] == 1'b0)
        begin
            status = msqrt_pkg::ST_BADMOD;
            return;
        end
        status = msqrt_pkg::ST_NONRES;
        a = a % p;
        if (!passes_euler(a, p))
            return;
        q = p - 1;
        m = 0;
        while (q[0] == 1'b0)
        begin
            q = q >> 1;
            m++;
        end
        for (z = 1; z < p; z++)
            if (!passes_euler(z, p))
                break;
        if (z >= p)
            return;
        c = power_mod(z, q, p);
        t = power_mod(a, q, p);
        r = power_mod(a, (q + 1) >> 1, p);
        while (t != 1)
        begin
            if (t == 0)
                return;
            t2 = t;
            for (i = 1; i < m; i++)
            begin
                t2 = mult_mod(t2, t2, p);
                if (t2 == 1)
                    break;
            end
            if (i >= m)
                return;
            b = c;
            for (k = 0; k + i + 1 < m; k++)
                b = mult_mod(b, b, p);
            m = i;
            c = mult_mod(b, b, p);
            t = mult_mod(t, c, p);
            r = mult_mod(r, b, p);
        end
        root = r[31:0];
        status = msqrt_pkg::ST_OK;
    endfunction

    function void note_request(msqrt_pkg::word_t value, msqrt_pkg::word_t modulus);
        root_expect_t e;
        e.value = value;
        e.modulus = modulus;
        solve_root(value, modulus, e.root, e.status);
        expected_roots = {expected_roots, e};
    endfunction

    function void check_result(msqrt_pkg::word_t root, logic [1:0] status);
        root_expect_t e;
        if (expected_roots.size() == 0)
        begin
            $display("%0t: unexpected result root=%0d status=%0d", $time, root, status);
            errors++;
            return;
        end
        e = expected_roots.pop_front();
        if (status !== e.status)
        begin
            $display("%0t: status mismatch for %0d mod %0d: expected %0d, got %0d",
                     $time, e.value, e.modulus, e.status, status);
            errors++;
        end
        if (root !== e.root)
        begin
            $display("%0t: root mismatch for %0d mod %0d: expected %0d, got %0d",
                     $time, e.value, e.modulus, e.root, root);
            errors++;
        end
    endfunction

    function int pending();
        return expected_roots.size();
    endfunction
endclass

module modular_square_root_test;
    import msqrt_pkg::*;

    localparam longint CYCLE_LIMIT = 40000000;

    logic clk;
    logic rst_n;
    msqrt_in_if  din();
    msqrt_out_if dout();

    modular_square_root dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    sqrt_scoreboard sb;
    int             sender_idle_pct;
    int             receiver_stall_pct;
    longint         cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // timeout guard
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls, every accepted result checked
    always @(posedge clk)
    begin
        if (rst_n && dout.valid && dout.ready)
            sb.check_result(dout.root, dout.status);
        dout.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // trial division, good enough for 32-bit candidates
    function automatic bit is_prime(longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 0;
        if (n < 4)
            return 1;
        if (n[0] == 1'b0)
            return 0;
        for (d = 3; d * d <= n; d += 2)
            if (n % d == 0)
                return 0;
        return 1;
    endfunction

    function automatic word_t random_prime();
        longint unsigned n;
        do
        begin
            if ($urandom_range(99) < 60)
                n = {32'h0, $urandom} | 64'h8000_0001;
            else
                n = $urandom_range(65535, 3) | 1;
        end while (!is_prime(n));
        return n[31:0];
    endfunction

    // a square mod p, lifted by a random multiple of p to use the high bits
    function automatic word_t random_square(word_t modulus);
        longint unsigned p, x, s, room;
        p = modulus;
        x = {32'h0, $urandom} % p;
        s = (x * x) % p;
        room = (64'hFFFF_FFFF - s) / p;
        if (room > 64'hFFFF_FFFF)
            room = 64'hFFFF_FFFF;
        return word_t'(s + p * ({32'h0, $urandom} % (room + 1)));
    endfunction

    // hand one request over; the sender may idle first
    task automatic send_request(input word_t value, input word_t modulus);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            din.valid <= 1'b0;
            @(posedge clk);
        end
        din.valid   <= 1'b1;
        din.value   <= value;
        din.modulus <= modulus;
        do
            @(posedge clk);
        while (!din.ready);
        sb.note_request(value, modulus);
    endtask

    task automatic send_random();
        int    pick;
        word_t p;
        pick = $urandom_range(99);
        if (pick < 6)
            // even or tiny moduli
            send_request($urandom, ($urandom_range(1) ? $urandom & ~32'h1
                                                      : $urandom_range(2)));
        else if (pick < 12)
            // small odd moduli, prime or composite; no primality check in the block
            send_request($urandom, $urandom_range(499, 4) * 2 + 1);
        else
        begin
            p = random_prime();
            if ($urandom_range(99) < 65)
                send_request(random_square(p), p);
            else
                send_request($urandom, p);
        end
    endtask

    initial
    begin
        word_t edge_primes [6];
        sb = new();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        rst_n = 1'b0;
        din.valid = 1'b0;
        din.value = '0;
        din.modulus = '0;
        dout.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // primes with long chains of twos in p-1 and the largest 32-bit prime
        edge_primes = '{32'd3221225473, 32'd2013265921, 32'd998244353,
                        32'd65537, 32'd4294967291, 32'd17};

        // bad moduli: zero, one, two, largest even
        send_request(32'd5, 32'd0);
        send_request(32'hFFFF_FFFF, 32'd1);
        send_request(32'd1, 32'd2);
        send_request(32'd4, 32'hFFFF_FFFE);
        // value zero and value equal to the modulus fail the euler test
        send_request(32'd0, 32'd3);
        send_request(32'd4294967291, 32'd4294967291);
        // smallest odd prime, a residue and a non-residue
        send_request(32'd1, 32'd3);
        send_request(32'd2, 32'd3);
        // extreme values against the largest prime
        send_request(32'hFFFF_FFFF, 32'd4294967291);
        send_request(32'd4, 32'd4294967291);
        // small composites
        send_request(32'd4, 32'd9);
        send_request(32'd1, 32'd15);
        send_request(32'd7, 32'd21);
        foreach (edge_primes[j])
        begin
            send_request(random_square(edge_primes[j]), edge_primes[j]);
            send_request($urandom, edge_primes[j]);
        end

        // idling phases: none, sender, receiver, both
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct    = (phase == 1) ? 88 : (phase == 3) ? 31 : 0;
            receiver_stall_pct = (phase == 2) ? 88 : (phase == 3) ? 31 : 0;
            repeat (19) send_random();
        end
        din.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
